// ===== sv/csm_pkg.sv =====
`default_nettype none

package csm_pkg;

    localparam int STEP_WIDTH = 24;
    localparam int TIME_WIDTH = 32;

    localparam int STEP_OUT_W = 24;
    localparam int RPM_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int GAP_W      = 16;
    localparam int SPR_W      = 8;

    localparam int STEPS_PER_MIN_MUL = 60;
    localparam int RPM_SCALE         = 16000;
    localparam int FRAC_BITS         = 4;

    localparam int PROD_W = STEP_WIDTH + 6;
    localparam int NUM_W  = PROD_W + 14;
    localparam int HI_W   = NUM_W - RPM_W;
    localparam int REM_W  = ((TIME_WIDTH > HI_W) ? TIME_WIDTH : HI_W) + 1;
    localparam int CNT_W  = $clog2(PROD_W + 1);
    localparam int STEP_EXT_W = (STEP_WIDTH > STEP_OUT_W) ? STEP_WIDTH : STEP_OUT_W;

    localparam logic [STEP_OUT_W-1:0] STEP_OUT_MAX = '1;
    localparam logic [RPM_W-1:0]      RPM_MAX      = '1;

    localparam logic [GAP_W-1:0] MIN_RUN_RST  = GAP_W'(1000);
    localparam logic [GAP_W-1:0] MAX_GAP_RST  = GAP_W'(1000);
    localparam logic [SPR_W-1:0] SPR_RST      = SPR_W'(12);
    localparam logic [SPR_W-1:0] SETTLE_RST   = SPR_W'(3);

    localparam logic [1:0] KIND_MOVE  = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SPR     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = CFG_IDX_W'(3);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV1,
        S_MUL,
        S_SAT,
        S_DIV2,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/conveyor_stall_monitor.sv =====
`default_nettype none

// Belt motor stall monitor. Each accepted word (move request, error clear or
// 1 ms tick) updates the monitor state in the cycle it is taken and yields one
// result word. The RPM figure is produced by a single compare-subtract unit
// that first divides steps*60 by steps_per_rev one bit per cycle, then,
// after a multiply by 16000 and a saturation check, divides by the run time;
// both divisions are skipped and the RPM is zero when timing is idle or
// steps_per_rev is zero. The input is not ready until the item's result
// has been loaded into the output register, where it waits while the next
// word is taken.
module conveyor_stall_monitor (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [1:0]                        i_kind,
    input  wire logic                              i_move_value,
    input  wire logic                              i_step_edge,
    input  wire logic                              i_box_rise,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_relay_on,
    output logic                                   o_stall_error,
    output logic                                   o_check_enabled,
    output logic                                   o_box_in_position,
    output logic [csm_pkg::STEP_OUT_W-1:0]         o_step_count,
    output logic [csm_pkg::RPM_W-1:0]              o_rpm_fixed,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [csm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [csm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import csm_pkg::*;

    t_state                r_state, n_state;
    logic                  r_move, n_move;
    logic                  r_fault, n_fault;
    logic                  r_check, n_check;
    logic                  r_active, n_active;
    logic [TIME_WIDTH-1:0] r_run, n_run;
    logic [TIME_WIDTH-1:0] r_gap, n_gap;
    logic [STEP_WIDTH-1:0] r_steps, n_steps;
    logic [STEP_WIDTH-1:0] r_target, n_target;
    logic                  r_armed, n_armed;

    logic [NUM_W-1:0]      r_dvd, n_dvd;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [RPM_W-1:0]      r_rpm, n_rpm;

    logic                  r_out_valid, n_out_valid;
    logic                  r_o_relay, n_o_relay;
    logic                  r_o_fault, n_o_fault;
    logic                  r_o_check, n_o_check;
    logic                  r_o_box, n_o_box;
    logic [STEP_OUT_W-1:0] r_o_steps, n_o_steps;
    logic [RPM_W-1:0]      r_o_rpm, n_o_rpm;

    logic [GAP_W-1:0]      r_min_run;
    logic [GAP_W-1:0]      r_max_gap;
    logic [SPR_W-1:0]      r_spr;
    logic [SPR_W-1:0]      r_settle;

    logic [TIME_WIDTH-1:0] run_inc, gap_inc, t_run, t_gap;
    logic [STEP_WIDTH-1:0] steps_inc, t_steps;
    logic [STEP_WIDTH:0]   tgt_sum;
    logic                  t_chk;
    logic [REM_W-1:0]      rem_sh, dvs;
    logic                  ge;
    logic [STEP_EXT_W-1:0] steps_ext;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_run <= MIN_RUN_RST;
            r_max_gap <= MAX_GAP_RST;
            r_spr     <= SPR_RST;
            r_settle  <= SETTLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MIN_RUN: r_min_run <= i_cfg_data;
                REG_MAX_GAP: r_max_gap <= i_cfg_data;
                REG_SPR:     r_spr     <= i_cfg_data[SPR_W-1:0];
                REG_SETTLE:  r_settle  <= i_cfg_data[SPR_W-1:0];
                default: ;
            endcase
        end
    end

    // shared compare-subtract unit
    assign rem_sh = {r_rem[REM_W-2:0], r_dvd[NUM_W-1]};
    assign dvs    = (r_state == S_DIV2) ? REM_W'(r_run) : REM_W'(r_spr);
    assign ge     = (rem_sh >= dvs);

    assign run_inc   = (&r_run) ? r_run : r_run + 1'b1;
    assign gap_inc   = (&r_gap) ? r_gap : r_gap + 1'b1;
    assign steps_inc = (&r_steps) ? r_steps : r_steps + 1'b1;
    assign steps_ext = STEP_EXT_W'(r_steps);

    always_comb begin
        n_state     = r_state;
        n_move      = r_move;
        n_fault     = r_fault;
        n_check     = r_check;
        n_active    = r_active;
        n_run       = r_run;
        n_gap       = r_gap;
        n_steps     = r_steps;
        n_target    = r_target;
        n_armed     = r_armed;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_rpm       = r_rpm;
        n_out_valid = r_out_valid;
        n_o_relay   = r_o_relay;
        n_o_fault   = r_o_fault;
        n_o_check   = r_o_check;
        n_o_box     = r_o_box;
        n_o_steps   = r_o_steps;
        n_o_rpm     = r_o_rpm;
        t_run       = '0;
        t_gap       = '0;
        t_steps     = r_steps;
        t_chk       = r_check;
        tgt_sum     = '0;
        o_ready     = (r_state == S_IDLE);

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOAD;
                    case (i_kind)
                        KIND_MOVE: begin
                            n_move = r_fault ? 1'b0 : i_move_value;
                        end
                        KIND_CLEAR: begin
                            n_fault = 1'b0;
                        end
                        KIND_TICK: begin
                            if (!r_move) begin
                                n_steps  = '0;
                                n_run    = '0;
                                n_gap    = '0;
                                n_active = 1'b0;
                                n_armed  = 1'b0;
                            end else begin
                                t_run   = r_active ? run_inc : '0;
                                t_gap   = r_active ? gap_inc : '0;
                                t_chk   = r_check | (t_run >= TIME_WIDTH'(r_min_run));
                                t_steps = i_step_edge ? steps_inc : r_steps;
                                if (i_step_edge) begin
                                    t_gap = '0;
                                end
                                if (i_box_rise) begin
                                    tgt_sum  = {1'b0, t_steps} + (STEP_WIDTH + 1)'(r_settle);
                                    n_target = tgt_sum[STEP_WIDTH] ? '1 :
                                               tgt_sum[STEP_WIDTH-1:0];
                                    n_armed  = 1'b1;
                                end
                                if (t_chk && (t_gap > TIME_WIDTH'(r_max_gap))) begin
                                    n_fault = 1'b1;
                                end
                                n_active = 1'b1;
                                n_run    = t_run;
                                n_gap    = t_gap;
                                n_check  = t_chk;
                                n_steps  = t_steps;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD: begin
                n_rem = '0;
                n_cnt = '0;
                n_dvd = {PROD_W'(r_steps) * PROD_W'(STEPS_PER_MIN_MUL),
                         (NUM_W - PROD_W)'(0)};
                if (!r_active || (r_spr == '0)) begin
                    n_rpm   = '0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV1;
                end
            end
            S_DIV1: begin
                n_rem = ge ? rem_sh - dvs : rem_sh;
                n_dvd = {r_dvd[NUM_W-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PROD_W - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_dvd   = NUM_W'(NUM_W'(r_dvd[PROD_W-1:0]) * NUM_W'(RPM_SCALE));
                n_state = S_SAT;
            end
            S_SAT: begin
                n_cnt = '0;
                if (r_run == '0) begin
                    n_rpm   = (r_dvd != '0) ? RPM_MAX : '0;
                    n_state = S_DONE;
                end else if (REM_W'(r_dvd[NUM_W-1:RPM_W]) >= REM_W'(r_run)) begin
                    n_rpm   = RPM_MAX;
                    n_state = S_DONE;
                end else begin
                    n_rem   = REM_W'(r_dvd[NUM_W-1:RPM_W]);
                    n_dvd   = {r_dvd[RPM_W-1:0], HI_W'(0)};
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                n_rem = ge ? rem_sh - dvs : rem_sh;
                n_dvd = {r_dvd[NUM_W-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RPM_W - 1)) begin
                    n_rpm   = {r_dvd[RPM_W-2:0], ge};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_o_relay   = r_move & ~r_fault;
                    n_o_fault   = r_fault;
                    n_o_check   = r_check;
                    n_o_box     = r_armed && (r_steps >= r_target);
                    n_o_steps   = (steps_ext > STEP_EXT_W'(STEP_OUT_MAX)) ? STEP_OUT_MAX :
                                  steps_ext[STEP_OUT_W-1:0];
                    n_o_rpm     = r_rpm;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_move      <= 1'b0;
            r_fault     <= 1'b0;
            r_check     <= 1'b0;
            r_active    <= 1'b0;
            r_run       <= '0;
            r_gap       <= '0;
            r_steps     <= '0;
            r_target    <= '0;
            r_armed     <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_move      <= n_move;
            r_fault     <= n_fault;
            r_check     <= n_check;
            r_active    <= n_active;
            r_run       <= n_run;
            r_gap       <= n_gap;
            r_steps     <= n_steps;
            r_target    <= n_target;
            r_armed     <= n_armed;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_rpm     <= n_rpm;
        r_o_relay <= n_o_relay;
        r_o_fault <= n_o_fault;
        r_o_check <= n_o_check;
        r_o_box   <= n_o_box;
        r_o_steps <= n_o_steps;
        r_o_rpm   <= n_o_rpm;
    end

    assign o_valid           = r_out_valid;
    assign o_relay_on        = r_o_relay;
    assign o_stall_error     = r_o_fault;
    assign o_check_enabled   = r_o_check;
    assign o_box_in_position = r_o_box;
    assign o_step_count      = r_o_steps;
    assign o_rpm_fixed       = r_o_rpm;

endmodule

`default_nettype wire

// ===== sv/csm_checker.sv =====
`default_nettype none

module csm_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_valid,
    input wire logic                              o_ready,
    input wire logic                              o_valid,
    input wire logic                              i_ready,
    input wire logic                              o_relay_on,
    input wire logic                              o_stall_error,
    input wire logic [csm_pkg::STEP_OUT_W-1:0]    o_step_count,
    input wire logic [csm_pkg::RPM_W-1:0]         o_rpm_fixed
);
    import csm_pkg::*;

    a_relay_off_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_relay_on && o_stall_error))
        else $error("relay driven while stall fault latched");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready right after an accepted word");

    a_no_steps_no_rpm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_step_count == '0)) |-> (o_rpm_fixed == '0))
        else $error("nonzero rpm with zero step count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_rpm_fixed)))
        else $error("stalled result word changed");

endmodule

bind conveyor_stall_monitor csm_checker u_csm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_relay_on    (o_relay_on),
    .o_stall_error (o_stall_error),
    .o_step_count  (o_step_count),
    .o_rpm_fixed   (o_rpm_fixed)
);

`default_nettype wire
